[hdl/pmra_pkg.sv]
// shared types and codes for the page map run allocator
package pmra_pkg;

  localparam int PAGE_W = 12;
  localparam int LEN_W  = 13;
  localparam int CFG_W  = 13;

  typedef logic [1:0] owner_t;
  typedef logic [2:0] req_t;
  typedef logic [1:0] status_t;

  localparam owner_t OWN_FREE   = 2'd0;
  localparam owner_t OWN_KERNEL = 2'd1;
  localparam owner_t OWN_USER   = 2'd2;
  localparam owner_t OWN_BAD    = 2'd3;

  localparam req_t REQ_ALLOC     = 3'd0;
  localparam req_t REQ_FREE      = 3'd1;
  localparam req_t REQ_FIND_LOW  = 3'd2;
  localparam req_t REQ_FIND_HIGH = 3'd3;
  localparam req_t REQ_MARK      = 3'd4;

  localparam status_t ST_DONE   = 2'd0;
  localparam status_t ST_NONE   = 2'd1;
  localparam status_t ST_DENIED = 2'd2;

  localparam logic [CFG_W-1:0] PAGES_RESET = 13'd4096;

  typedef struct packed {
    status_t             status;
    logic [PAGE_W-1:0]   page;
  } result_t;

endpackage

[hdl/page_map_run_allocator.sv]
// page owner map with contiguous run allocation, top level
//
// input channel: in_valid/in_stall with req_type, run_length, page_number,
// requester_is_kernel and mark_owner; one transaction is one request.
// output channel: out_valid/out_stall with status and found_page; each
// request gives exactly one result transaction, in request order.
// cfg_we/cfg_data write pages_in_use; the user must write it only while no
// request is open, the block itself does not enforce this. a scan reads one
// page per cycle from the single read port of the owner store.
// one request is worked on at a time; a finished result moves to the output
// register, so the next request is taken while that result waits.
// a stalled output holds its result and the sequencer waits for the slot.
// reset: the store is cleared to free by a pass over all MAX_PAGES entries, one
// entry per cycle, with in_stall high; pages_in_use resets to 4096.
module page_map_run_allocator #(
  parameter int MAX_PAGES = 4096
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [2:0]                         req_type,
  input  logic [12:0]                        run_length,
  input  logic [11:0]                        page_number,
  input  logic                               requester_is_kernel,
  input  logic [1:0]                         mark_owner,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         status,
  output logic [11:0]                        found_page,
  input  logic                               cfg_we,
  input  logic [12:0]                        cfg_data
);

  localparam int AW  = $clog2(MAX_PAGES);
  localparam int EW0 = $clog2(MAX_PAGES + 1);
  localparam int EW  = (EW0 > pmra_pkg::CFG_W) ? EW0 : pmra_pkg::CFG_W;

  logic [pmra_pkg::CFG_W-1:0] pages_in_use;
  logic                       done_ready;
  logic                       res_push;
  pmra_pkg::result_t          res;
  logic [AW-1:0]              rd_addr;
  pmra_pkg::owner_t           rd_data;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  pmra_pkg::owner_t           wr_data;

  assign done_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pages_in_use <= pmra_pkg::PAGES_RESET;
    end else if (cfg_we) begin
      pages_in_use <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      status     <= res.status;
      found_page <= res.page;
    end
  end

  pmra_mem #(
    .MAX_PAGES (MAX_PAGES),
    .AW        (AW)
  ) u_mem (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  pmra_seq #(
    .MAX_PAGES (MAX_PAGES),
    .AW        (AW),
    .EW        (EW)
  ) u_seq (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .req_type            (req_type),
    .run_length          (run_length),
    .page_number         (page_number),
    .requester_is_kernel (requester_is_kernel),
    .mark_owner          (mark_owner),
    .pages_in_use        (pages_in_use),
    .done_ready          (done_ready),
    .res_push            (res_push),
    .res                 (res),
    .rd_addr             (rd_addr),
    .rd_data             (rd_data),
    .wr_en               (wr_en),
    .wr_addr             (wr_addr),
    .wr_data             (wr_data)
  );

endmodule

[hdl/pmra_mem.sv]
// owner code store, one write port and one registered read port
module pmra_mem #(
  parameter int MAX_PAGES = 4096,
  parameter int AW = 12
) (
  input  logic                clk,
  input  logic [AW-1:0]       rd_addr,
  output pmra_pkg::owner_t    rd_data,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  pmra_pkg::owner_t    wr_data
);

  pmra_pkg::owner_t mem [MAX_PAGES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[hdl/pmra_seq.sv]
// request sequencer: clearing pass, page scans and read-modify-write of the store
module pmra_seq #(
  parameter int MAX_PAGES = 4096,
  parameter int AW = 12,
  parameter int EW = 13
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  pmra_pkg::req_t                     req_type,
  input  logic [pmra_pkg::LEN_W-1:0]         run_length,
  input  logic [pmra_pkg::PAGE_W-1:0]        page_number,
  input  logic                               requester_is_kernel,
  input  pmra_pkg::owner_t                   mark_owner,
  input  logic [pmra_pkg::CFG_W-1:0]         pages_in_use,
  input  logic                               done_ready,
  output logic                               res_push,
  output pmra_pkg::result_t                  res,
  output logic [AW-1:0]                      rd_addr,
  input  pmra_pkg::owner_t                   rd_data,
  output logic                               wr_en,
  output logic [AW-1:0]                      wr_addr,
  output pmra_pkg::owner_t                   wr_data
);

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_WRITE    = 3'd3;
  localparam logic [2:0] S_FREE_RD  = 3'd4;
  localparam logic [2:0] S_FREE_CHK = 3'd5;
  localparam logic [2:0] S_MARK     = 3'd6;
  localparam logic [2:0] S_RESULT   = 3'd7;

  localparam logic [EW-1:0] MAX_E  = EW'(MAX_PAGES);
  localparam logic [EW-1:0] LAST_E = EW'(MAX_PAGES - 1);
  localparam logic [EW-1:0] ONE_E  = EW'(1);
  localparam logic [EW-1:0] TWO_E  = EW'(2);

  logic [2:0]                     state, state_next;
  logic [EW-1:0]                  iss_addr, iss_addr_next;
  logic                           iss_live, iss_live_next;
  logic                           pend, pend_next;
  logic [EW-1:0]                  dat_addr, dat_addr_next;
  logic [pmra_pkg::LEN_W-1:0]     count, count_next;
  logic [EW-1:0]                  top_page, top_page_next;
  pmra_pkg::req_t                 req, req_next;
  logic [pmra_pkg::LEN_W-1:0]     len, len_next;
  logic [EW-1:0]                  pg, pg_next;
  logic                           kern, kern_next;
  pmra_pkg::owner_t               own, own_next;
  logic [EW-1:0]                  peff, peff_next;
  pmra_pkg::result_t              res_next;

  logic [EW-1:0]                  cfg_ext;
  logic [EW-1:0]                  peff_c;
  logic [EW-1:0]                  pg_in;
  logic                           down;
  logic [EW-1:0]                  last;
  logic                           is_free;

  assign cfg_ext  = EW'(pages_in_use);
  assign peff_c   = (cfg_ext > MAX_E) ? MAX_E : cfg_ext;
  assign pg_in    = EW'(page_number);
  assign down     = (req != pmra_pkg::REQ_FIND_LOW);
  assign last     = down ? ONE_E : (peff - ONE_E);
  assign is_free  = (rd_data == pmra_pkg::OWN_FREE);
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next    = state;
    iss_addr_next = iss_addr;
    iss_live_next = iss_live;
    pend_next     = pend;
    dat_addr_next = dat_addr;
    count_next    = count;
    top_page_next = top_page;
    req_next      = req;
    len_next      = len;
    pg_next       = pg;
    kern_next     = kern;
    own_next      = own;
    peff_next     = peff;
    res_next      = res;
    res_push      = 1'b0;
    rd_addr       = iss_addr[AW-1:0];
    wr_en         = 1'b0;
    wr_addr       = iss_addr[AW-1:0];
    wr_data       = pmra_pkg::OWN_FREE;

    case (state)
      S_CLEAR: begin
        wr_en = 1'b1;
        if (iss_addr == LAST_E) begin
          state_next    = S_IDLE;
          iss_addr_next = '0;
        end else begin
          iss_addr_next = iss_addr + ONE_E;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          req_next      = req_type;
          len_next      = run_length;
          pg_next       = pg_in;
          kern_next     = requester_is_kernel;
          own_next      = mark_owner;
          peff_next     = peff_c;
          count_next    = '0;
          pend_next     = 1'b0;
          iss_live_next = 1'b1;
          res_next      = '{status: pmra_pkg::ST_DONE, page: '0};
          state_next    = S_RESULT;
          case (req_type)
            pmra_pkg::REQ_ALLOC: begin
              if (run_length != '0 && peff_c >= TWO_E) begin
                state_next    = S_SCAN;
                iss_addr_next = peff_c - ONE_E;
              end else begin
                res_next.status = pmra_pkg::ST_NONE;
              end
            end
            pmra_pkg::REQ_FIND_HIGH: begin
              if (peff_c >= TWO_E) begin
                state_next    = S_SCAN;
                iss_addr_next = peff_c - ONE_E;
              end else begin
                res_next.status = pmra_pkg::ST_NONE;
              end
            end
            pmra_pkg::REQ_FIND_LOW: begin
              if (peff_c >= TWO_E) begin
                state_next    = S_SCAN;
                iss_addr_next = ONE_E;
              end else begin
                res_next.status = pmra_pkg::ST_NONE;
              end
            end
            pmra_pkg::REQ_FREE: begin
              if (pg_in < MAX_E) begin
                state_next = S_FREE_RD;
              end
            end
            pmra_pkg::REQ_MARK: begin
              if (pg_in < MAX_E && mark_owner != pmra_pkg::OWN_BAD) begin
                state_next = S_MARK;
              end
            end
            default: begin
              state_next = S_RESULT;
            end
          endcase
        end
      end

      S_SCAN: begin
        // issue one read a cycle, evaluate the page read in the cycle before
        pend_next     = iss_live;
        dat_addr_next = iss_addr;
        if (iss_live) begin
          iss_live_next = (iss_addr != last);
          iss_addr_next = down ? (iss_addr - ONE_E) : (iss_addr + ONE_E);
        end
        if (pend) begin
          if (req == pmra_pkg::REQ_ALLOC) begin
            if (is_free) begin
              if ((count + 1'b1) == len) begin
                state_next    = S_WRITE;
                iss_addr_next = dat_addr;
                top_page_next = dat_addr + EW'(len) - ONE_E;
              end else begin
                count_next = count + 1'b1;
              end
            end else begin
              count_next = '0;
            end
            if (!(is_free && (count + 1'b1) == len) && dat_addr == last) begin
              res_next   = '{status: pmra_pkg::ST_NONE, page: '0};
              state_next = S_RESULT;
            end
          end else begin
            if (is_free) begin
              res_next   = '{status: pmra_pkg::ST_DONE,
                             page: dat_addr[pmra_pkg::PAGE_W-1:0]};
              state_next = S_RESULT;
            end else if (dat_addr == last) begin
              res_next   = '{status: pmra_pkg::ST_NONE, page: '0};
              state_next = S_RESULT;
            end
          end
        end
      end

      S_WRITE: begin
        wr_en   = 1'b1;
        wr_data = kern ? pmra_pkg::OWN_KERNEL : pmra_pkg::OWN_USER;
        if (iss_addr == top_page) begin
          res_next   = '{status: pmra_pkg::ST_DONE,
                         page: top_page[pmra_pkg::PAGE_W-1:0]};
          state_next = S_RESULT;
        end else begin
          iss_addr_next = iss_addr + ONE_E;
        end
      end

      S_FREE_RD: begin
        rd_addr    = pg[AW-1:0];
        state_next = S_FREE_CHK;
      end

      S_FREE_CHK: begin
        if (rd_data == pmra_pkg::OWN_KERNEL && !kern) begin
          res_next.status = pmra_pkg::ST_DENIED;
        end else begin
          wr_en   = 1'b1;
          wr_addr = pg[AW-1:0];
          wr_data = pmra_pkg::OWN_FREE;
        end
        state_next = S_RESULT;
      end

      S_MARK: begin
        wr_en      = 1'b1;
        wr_addr    = pg[AW-1:0];
        wr_data    = own;
        state_next = S_RESULT;
      end

      S_RESULT: begin
        if (done_ready) begin
          res_push   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      iss_addr <= '0;
      iss_live <= 1'b0;
      pend     <= 1'b0;
    end else begin
      state    <= state_next;
      iss_addr <= iss_addr_next;
      iss_live <= iss_live_next;
      pend     <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    dat_addr <= dat_addr_next;
    count    <= count_next;
    top_page <= top_page_next;
    req      <= req_next;
    len      <= len_next;
    pg       <= pg_next;
    kern     <= kern_next;
    own      <= own_next;
    peff     <= peff_next;
    res      <= res_next;
  end

  a_push_ready: assert property (@(posedge clk) disable iff (rst)
    res_push |-> done_ready)
    else $error("result pushed while output slot busy");

  a_write_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |-> (iss_addr <= top_page && top_page < peff))
    else $error("run write outside found run");

  a_run_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && req == pmra_pkg::REQ_ALLOC) |-> (count < len))
    else $error("run count reached length without allocation");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && pend) |-> (dat_addr >= ONE_E && dat_addr < peff))
    else $error("scan read outside managed pages");

endmodule
